/* hdl/ipq_pkg.sv */
// ----------------------------------------------------------------------------
// ipq_pkg
// Shared types and constants of the indexed priority queue: command and
// status codes, register indexes, port widths and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package ipq_pkg;

	localparam int OP_W    = 2;
	localparam int ID_W    = 8;
	localparam int LVL_W   = 7;
	localparam int ST_W    = 2;
	localparam int WIDX_W  = 1;
	localparam int TMP_W   = 18;

	localparam int DEF_MAX_ENTRIES = 256;
	localparam int DEF_LEVEL_BITS  = 7;

	localparam logic [LVL_W-1:0] MIN_LEVEL_RST = 7'd30;
	localparam logic [LVL_W-1:0] LEVEL_CAP_RST = 7'd100;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_INCREASE = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_PEEK     = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	typedef enum logic [WIDX_W-1:0] {
		REG_MIN_LEVEL = 1'd0,
		REG_LEVEL_CAP = 1'd1
	} reg_idx_t;

	// control word that travels down the row with each transaction
	typedef struct packed {
		logic    valid;
		op_t     op;
		logic    seek;
		status_t status;
	} ctl_t;

endpackage

`default_nettype wire

/* hdl/ipq_cell.sv */
// ----------------------------------------------------------------------------
// ipq_cell
// One queue entry: live mark and level. Applies insert, increase and remove
// when addressed and folds its entry into a passing peek, then hands the
// transaction to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ipq_cell #(
	parameter int CELL_ID    = 0,
	parameter int ID_BITS    = 8,
	parameter int LEVEL_BITS = 7,
	parameter int ARG_BITS   = 7
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire  [LEVEL_BITS-1:0]      min_level,
	input  wire  [LEVEL_BITS-1:0]      level_cap,
	input  wire  ipq_pkg::ctl_t        ctl_in,
	input  wire  [ID_BITS-1:0]         id_in,
	input  wire  [ARG_BITS-1:0]        arg_in,
	input  wire  [ID_BITS-1:0]         rid_in,
	input  wire  [LEVEL_BITS-1:0]      rlvl_in,
	output ipq_pkg::ctl_t              ctl_out,
	output logic [ID_BITS-1:0]         id_out,
	output logic [ARG_BITS-1:0]        arg_out,
	output logic [ID_BITS-1:0]         rid_out,
	output logic [LEVEL_BITS-1:0]      rlvl_out
);
	import ipq_pkg::*;

	localparam logic [ID_BITS-1:0] MY_ID = ID_BITS'(CELL_ID);

	logic                  live_q;
	logic [LEVEL_BITS-1:0] lvl_q;
	ctl_t                  ctl_q;
	logic [ID_BITS-1:0]    id_q;
	logic [ARG_BITS-1:0]   arg_q;
	logic [ID_BITS-1:0]    rid_q;
	logic [LEVEL_BITS-1:0] rlvl_q;

	logic                  hit;
	logic [ARG_BITS:0]     sum;
	logic [LEVEL_BITS-1:0] inc_lvl;
	logic                  live_d;
	logic                  lvl_we;
	logic [LEVEL_BITS-1:0] lvl_d;
	ctl_t                  ctl_d;
	logic [ID_BITS-1:0]    rid_d;
	logic [LEVEL_BITS-1:0] rlvl_d;

	assign hit = ctl_in.valid && ctl_in.seek && (id_in == MY_ID);
	assign sum = (ARG_BITS+1)'(lvl_q) + (ARG_BITS+1)'(arg_in);

	always_comb begin
		if (lvl_q < level_cap) begin
			inc_lvl = (sum > (ARG_BITS+1)'(level_cap)) ? level_cap : sum[LEVEL_BITS-1:0];
		end else begin
			inc_lvl = lvl_q;
		end
	end

	always_comb begin
		ctl_d  = ctl_in;
		rid_d  = rid_in;
		rlvl_d = rlvl_in;
		live_d = live_q;
		lvl_we = 1'b0;
		lvl_d  = inc_lvl;
		if (ctl_in.valid) begin
			case (ctl_in.op)
				OP_INSERT: begin
					if (hit) begin
						live_d     = 1'b1;
						lvl_we     = 1'b1;
						lvl_d      = arg_in[LEVEL_BITS-1:0];
						ctl_d.seek = 1'b0;
					end
				end
				OP_INCREASE: begin
					if (hit) begin
						ctl_d.seek = 1'b0;
						if (live_q) begin
							lvl_we       = 1'b1;
							ctl_d.status = ST_OK;
							rlvl_d       = inc_lvl;
						end
					end
				end
				OP_REMOVE: begin
					if (hit) begin
						ctl_d.seek = 1'b0;
						if (live_q) begin
							live_d       = 1'b0;
							ctl_d.status = ST_OK;
							rlvl_d       = '0;
						end
					end
				end
				OP_PEEK: begin
					if (live_q && (lvl_q >= min_level) &&
						((ctl_in.status != ST_OK) || (lvl_q > rlvl_in))) begin
						ctl_d.status = ST_OK;
						rid_d        = MY_ID;
						rlvl_d       = lvl_q;
					end
				end
				default: begin
					ctl_d = ctl_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			ctl_q  <= '0;
		end else begin
			live_q <= live_d;
			ctl_q  <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (lvl_we) begin
			lvl_q <= lvl_d;
		end
		id_q   <= id_in;
		arg_q  <= arg_in;
		rid_q  <= rid_d;
		rlvl_q <= rlvl_d;
	end

	assign ctl_out  = ctl_q;
	assign id_out   = id_q;
	assign arg_out  = arg_q;
	assign rid_out  = rid_q;
	assign rlvl_out = rlvl_q;

endmodule

`default_nettype wire

/* hdl/ipq_issue.sv */
// ----------------------------------------------------------------------------
// ipq_issue
// Front of the row: assigns arrival-ordered ids, clamps inserted levels,
// checks id range and presets the result of each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ipq_issue #(
	parameter int MAX_ENTRIES = 256,
	parameter int ID_BITS     = 8,
	parameter int LEVEL_BITS  = 7,
	parameter int ARG_BITS    = 7
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         accept,
	input  wire  [ipq_pkg::OP_W-1:0]    op,
	input  wire  [ipq_pkg::ID_W-1:0]    entry_id,
	input  wire  [ipq_pkg::LVL_W-1:0]   level,
	input  wire  [ipq_pkg::LVL_W-1:0]   increment,
	input  wire  [LEVEL_BITS-1:0]       level_cap,
	output ipq_pkg::ctl_t               ctl,
	output logic [ID_BITS-1:0]          id,
	output logic [ARG_BITS-1:0]         arg,
	output logic [ID_BITS-1:0]          rid,
	output logic [LEVEL_BITS-1:0]       rlvl
);
	import ipq_pkg::*;

	localparam int NID_BITS = $clog2(MAX_ENTRIES + 1);
	localparam logic [NID_BITS-1:0] NID_FULL = NID_BITS'(MAX_ENTRIES);

	logic [NID_BITS-1:0]   next_id_q;
	logic [TMP_W-1:0]      id_wide;
	logic [TMP_W-1:0]      lvl_wide;
	logic [LEVEL_BITS-1:0] lvl_in;
	logic [LEVEL_BITS-1:0] lvl_clamp;
	logic                  full;
	op_t                   op_c;

	assign op_c      = op_t'(op);
	assign id_wide   = TMP_W'(entry_id);
	assign lvl_wide  = TMP_W'(level);
	assign lvl_in    = lvl_wide[LEVEL_BITS-1:0];
	assign lvl_clamp = (lvl_in > level_cap) ? level_cap : lvl_in;
	assign full      = (next_id_q == NID_FULL);

	always_comb begin
		ctl.valid  = accept;
		ctl.op     = op_c;
		ctl.seek   = 1'b0;
		ctl.status = ST_EMPTY;
		id         = id_wide[ID_BITS-1:0];
		arg        = ARG_BITS'(increment);
		rid        = '0;
		rlvl       = '0;
		case (op_c)
			OP_INSERT: begin
				if (full) begin
					ctl.status = ST_FULL;
				end else begin
					ctl.status = ST_OK;
					ctl.seek   = 1'b1;
					id         = next_id_q[ID_BITS-1:0];
					arg        = ARG_BITS'(lvl_clamp);
					rid        = next_id_q[ID_BITS-1:0];
					rlvl       = lvl_clamp;
				end
			end
			OP_INCREASE, OP_REMOVE: begin
				ctl.status = ST_UNKNOWN;
				ctl.seek   = (id_wide < TMP_W'(MAX_ENTRIES));
			end
			OP_PEEK: begin
				ctl.status = ST_EMPTY;
			end
			default: begin
				ctl.status = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= '0;
		end else if (accept && (op_c == OP_INSERT) && !full) begin
			next_id_q <= next_id_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

/* hdl/indexed_priority_queue.sv */
// ----------------------------------------------------------------------------
// indexed_priority_queue
// Indexed max-priority queue built as a row of entry cells. Each command
// walks the row one cell per cycle; the addressed cell applies it and every
// cell folds its entry into a passing peek.
//
// channel   signals                                     transfer
// command   start, busy, op, entry_id, level, increment start && !busy
// result    done, status, result_id, result_level       done, one cycle
// config    wr_en, wr_index, wr_data                     wr_en
//
// a new command is taken every cycle; busy is always low
// each command is registered once in every cell of the row before its result
// commands overtake nothing, so each sees all earlier updates
// reset clears every live mark, the id counter and the row
// the receiver cannot stall: done is high for one cycle per command
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_priority_queue #(
	parameter int MAX_ENTRIES = ipq_pkg::DEF_MAX_ENTRIES,
	parameter int LEVEL_BITS  = ipq_pkg::DEF_LEVEL_BITS
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire  [ipq_pkg::OP_W-1:0]   op,
	input  wire  [ipq_pkg::ID_W-1:0]   entry_id,
	input  wire  [ipq_pkg::LVL_W-1:0]  level,
	input  wire  [ipq_pkg::LVL_W-1:0]  increment,
	output logic                       done,
	output logic [ipq_pkg::ST_W-1:0]   status,
	output logic [ipq_pkg::ID_W-1:0]   result_id,
	output logic [ipq_pkg::LVL_W-1:0]  result_level,
	input  wire                        wr_en,
	input  wire  [ipq_pkg::WIDX_W-1:0] wr_index,
	input  wire  [ipq_pkg::LVL_W-1:0]  wr_data
);
	import ipq_pkg::*;

	localparam int ID_BITS  = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
	localparam int ARG_BITS = (LEVEL_BITS > LVL_W) ? LEVEL_BITS : LVL_W;

	logic [LEVEL_BITS-1:0] min_level_q;
	logic [LEVEL_BITS-1:0] level_cap_q;
	logic [TMP_W-1:0]      wr_wide;
	logic [TMP_W-1:0]      rid_wide;
	logic [TMP_W-1:0]      rlvl_wide;

	ctl_t                  ctl_w  [MAX_ENTRIES+1];
	logic [ID_BITS-1:0]    id_w   [MAX_ENTRIES+1];
	logic [ARG_BITS-1:0]   arg_w  [MAX_ENTRIES+1];
	logic [ID_BITS-1:0]    rid_w  [MAX_ENTRIES+1];
	logic [LEVEL_BITS-1:0] rlvl_w [MAX_ENTRIES+1];

	assign busy    = 1'b0;
	assign wr_wide = TMP_W'(wr_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= LEVEL_BITS'(MIN_LEVEL_RST);
			level_cap_q <= LEVEL_BITS'(LEVEL_CAP_RST);
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MIN_LEVEL: min_level_q <= wr_wide[LEVEL_BITS-1:0];
				REG_LEVEL_CAP: level_cap_q <= wr_wide[LEVEL_BITS-1:0];
				default: begin
					min_level_q <= min_level_q;
				end
			endcase
		end
	end

	ipq_issue #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.ID_BITS     (ID_BITS),
		.LEVEL_BITS  (LEVEL_BITS),
		.ARG_BITS    (ARG_BITS)
	) u_issue (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (start && !busy),
		.op        (op),
		.entry_id  (entry_id),
		.level     (level),
		.increment (increment),
		.level_cap (level_cap_q),
		.ctl       (ctl_w[0]),
		.id        (id_w[0]),
		.arg       (arg_w[0]),
		.rid       (rid_w[0]),
		.rlvl      (rlvl_w[0])
	);

	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		ipq_cell #(
			.CELL_ID    (k),
			.ID_BITS    (ID_BITS),
			.LEVEL_BITS (LEVEL_BITS),
			.ARG_BITS   (ARG_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.min_level (min_level_q),
			.level_cap (level_cap_q),
			.ctl_in    (ctl_w[k]),
			.id_in     (id_w[k]),
			.arg_in    (arg_w[k]),
			.rid_in    (rid_w[k]),
			.rlvl_in   (rlvl_w[k]),
			.ctl_out   (ctl_w[k+1]),
			.id_out    (id_w[k+1]),
			.arg_out   (arg_w[k+1]),
			.rid_out   (rid_w[k+1]),
			.rlvl_out  (rlvl_w[k+1])
		);
	end

	assign rid_wide     = TMP_W'(rid_w[MAX_ENTRIES]);
	assign rlvl_wide    = TMP_W'(rlvl_w[MAX_ENTRIES]);
	assign done         = ctl_w[MAX_ENTRIES].valid;
	assign status       = ctl_w[MAX_ENTRIES].status;
	assign result_id    = rid_wide[ID_W-1:0];
	assign result_level = rlvl_wide[LVL_W-1:0];

endmodule

`default_nettype wire

/* tb/sv/ipq_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipq_checker
// Watches the command, result and register channels of the indexed priority
// queue. It keeps its own copy of entry levels, live marks, the id counter and
// both registers, works out the reply to each accepted transaction, and
// compares every result with the oldest outstanding reply, field by field.
// ----------------------------------------------------------------------------
module ipq_checker import ipq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [OP_W-1:0]   op,
	input  logic [ID_W-1:0]   entry_id,
	input  logic [LVL_W-1:0]  level,
	input  logic [LVL_W-1:0]  increment,
	input  logic              done,
	input  logic [ST_W-1:0]   status,
	input  logic [ID_W-1:0]   result_id,
	input  logic [LVL_W-1:0]  result_level,
	input  logic              wr_en,
	input  logic [WIDX_W-1:0] wr_index,
	input  logic [LVL_W-1:0]  wr_data,
	output int                failures,
	output int                pending,
	output int                n_ok,
	output int                n_empty,
	output int                n_full,
	output int                n_unknown
);

	localparam int ENTRIES = DEF_MAX_ENTRIES;

	typedef struct packed {
		status_t          st;
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] lvl;
	} reply_t;

	logic [LVL_W-1:0] entry_lvl [ENTRIES];
	bit               entry_live [ENTRIES];
	int               next_slot;
	int               live_total;
	logic [LVL_W-1:0] floor_lvl;
	logic [LVL_W-1:0] cap_lvl;
	reply_t           expected_replies [$];

	function automatic reply_t apply_command(input op_t o, input logic [ID_W-1:0] id,
			input logic [LVL_W-1:0] lv, input logic [LVL_W-1:0] inc);
		reply_t r;
		int     sum;
		int     best;
		bit     found;
		r.st  = ST_OK;
		r.id  = '0;
		r.lvl = '0;
		case (o)
			OP_INSERT: begin
				if (next_slot >= ENTRIES) begin
					r.st = ST_FULL;
				end else begin
					entry_lvl[next_slot]  = (lv > cap_lvl) ? cap_lvl : lv;
					entry_live[next_slot] = 1'b1;
					r.id  = next_slot[ID_W-1:0];
					r.lvl = entry_lvl[next_slot];
					next_slot++;
					live_total++;
				end
			end
			OP_INCREASE, OP_REMOVE: begin
				if (!entry_live[id]) begin
					r.st = ST_UNKNOWN;
				end else if (o == OP_REMOVE) begin
					entry_live[id] = 1'b0;
					live_total--;
				end else begin
					// entries already at or above the cap stay put
					if (entry_lvl[id] < cap_lvl) begin
						sum = int'(entry_lvl[id]) + int'(inc);
						entry_lvl[id] = (sum > int'(cap_lvl)) ? cap_lvl : sum[LVL_W-1:0];
					end
					r.lvl = entry_lvl[id];
				end
			end
			default: begin
				found = 1'b0;
				best  = 0;
				if (live_total != 0) begin
					// strict compare keeps the smallest id on ties
					for (int i = 0; i < ENTRIES; i++) begin
						if (entry_live[i] && entry_lvl[i] >= floor_lvl &&
								(!found || entry_lvl[i] > entry_lvl[best])) begin
							found = 1'b1;
							best  = i;
						end
					end
				end
				if (found) begin
					r.id  = best[ID_W-1:0];
					r.lvl = entry_lvl[best];
				end else begin
					r.st = ST_EMPTY;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			expected_replies.delete();
			for (int i = 0; i < ENTRIES; i++) begin
				entry_live[i] = 1'b0;
				entry_lvl[i]  = '0;
			end
			next_slot  = 0;
			live_total = 0;
			floor_lvl  = MIN_LEVEL_RST;
			cap_lvl    = LEVEL_CAP_RST;
			pending    = 0;
			failures   = 0;
			n_ok       = 0;
			n_empty    = 0;
			n_full     = 0;
			n_unknown  = 0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_MIN_LEVEL) begin
					floor_lvl = wr_data;
				end else begin
					cap_lvl = wr_data;
				end
			end
			if (start && !busy) begin
				expected_replies = {expected_replies,
					apply_command(op_t'(op), entry_id, level, increment)};
			end
			if (done) begin
				if (expected_replies.size() == 0) begin
					$error("result with no outstanding transaction: status %0d id %0d level %0d",
						status, result_id, result_level);
					failures++;
				end else begin
					want = expected_replies.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						failures++;
					end
					if (result_id !== want.id) begin
						$error("result_id: expected %0d, got %0d", want.id, result_id);
						failures++;
					end
					if (result_level !== want.lvl) begin
						$error("result_level: expected %0d, got %0d", want.lvl, result_level);
						failures++;
					end
					case (want.st)
						ST_OK:    n_ok++;
						ST_EMPTY: n_empty++;
						ST_FULL:  n_full++;
						default:  n_unknown++;
					endcase
				end
			end
			pending = expected_replies.size();
		end
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the indexed priority queue: a directed run through empty and
// unknown-id cases, ties, clamping and saturation, then random command mixes
// under several register settings with changing sender gaps. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import ipq_pkg::*;

	localparam int LATENCY     = DEF_MAX_ENTRIES;
	localparam int CYCLE_LIMIT = 100000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 140;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	op_t              cmd_op    = OP_INSERT;
	logic [ID_W-1:0]  cmd_id    = '0;
	logic [LVL_W-1:0] cmd_level = '0;
	logic [LVL_W-1:0] cmd_inc   = '0;
	logic             wr_en     = 1'b0;
	reg_idx_t         wr_idx    = REG_MIN_LEVEL;
	logic [LVL_W-1:0] wr_val    = '0;

	logic             busy;
	logic             done;
	logic [ST_W-1:0]  status;
	logic [ID_W-1:0]  result_id;
	logic [LVL_W-1:0] result_level;

	int failures;
	int pending;
	int n_ok;
	int n_empty;
	int n_full;
	int n_unknown;
	int cycle_count    = 0;
	int sent           = 0;
	int inserts_sent   = 0;
	int settings_used  = 0;
	int idle_pct       = 0;

	always #5 clk = ~clk;

	indexed_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (cmd_op),
		.entry_id     (cmd_id),
		.level        (cmd_level),
		.increment    (cmd_inc),
		.done         (done),
		.status       (status),
		.result_id    (result_id),
		.result_level (result_level),
		.wr_en        (wr_en),
		.wr_index     (wr_idx),
		.wr_data      (wr_val)
	);

	ipq_checker queue_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (cmd_op),
		.entry_id     (cmd_id),
		.level        (cmd_level),
		.increment    (cmd_inc),
		.done         (done),
		.status       (status),
		.result_id    (result_id),
		.result_level (result_level),
		.wr_en        (wr_en),
		.wr_index     (wr_idx),
		.wr_data      (wr_val),
		.failures     (failures),
		.pending      (pending),
		.n_ok         (n_ok),
		.n_empty      (n_empty),
		.n_full       (n_full),
		.n_unknown    (n_unknown)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d transactions outstanding",
				cycle_count, pending);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic issue(input op_t o, input logic [ID_W-1:0] id,
			input logic [LVL_W-1:0] lv, input logic [LVL_W-1:0] inc);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		cmd_op    <= o;
		cmd_id    <= id;
		cmd_level <= lv;
		cmd_inc   <= inc;
		do @(posedge clk); while (busy);
		sent++;
		if (o == OP_INSERT) inserts_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_regs(input logic [LVL_W-1:0] floor_v, input logic [LVL_W-1:0] cap_v);
		wr_en  <= 1'b1;
		wr_idx <= REG_MIN_LEVEL;
		wr_val <= floor_v;
		@(posedge clk);
		wr_idx <= REG_LEVEL_CAP;
		wr_val <= cap_v;
		@(posedge clk);
		wr_en <= 1'b0;
		settings_used++;
	endtask

	// ids mostly near the newest ones, some anywhere already assigned, some arbitrary
	task automatic send_random();
		op_t              o;
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] inc;
		int               r;
		int               assigned;
		assigned = (inserts_sent > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : inserts_sent;
		r = $urandom_range(99);
		if (r < 35) o = OP_INSERT;
		else if (r < 65) o = OP_INCREASE;
		else if (r < 80) o = OP_REMOVE;
		else o = OP_PEEK;
		r = $urandom_range(3);
		if (assigned == 0 || r == 0) id = ID_W'($urandom_range(255));
		else if (r == 1) id = ID_W'($urandom_range(assigned - 1));
		else id = ID_W'($urandom_range(assigned - 1, (assigned > 24) ? assigned - 24 : 0));
		inc = ($urandom_range(2) == 0) ? LVL_W'($urandom_range(100)) :
			LVL_W'($urandom_range(12));
		issue(o, id, LVL_W'($urandom_range(100)), inc);
	endtask

	initial begin
		logic [LVL_W-1:0] floors [PHASES];
		logic [LVL_W-1:0] caps [PHASES];
		floors = '{7'd0, 7'd100, 7'd0, 7'd45, 7'd0, 7'd30};
		caps   = '{7'd100, 7'd100, 7'd0, 7'd60, 7'd0, 7'd100};
		floors[4] = LVL_W'($urandom_range(100));
		caps[4]   = LVL_W'($urandom_range(100));
		idle_pct = 19;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_regs(MIN_LEVEL_RST, LEVEL_CAP_RST);
		issue(OP_PEEK, 8'd0, 7'd0, 7'd0);
		issue(OP_INCREASE, 8'd0, 7'd0, 7'd5);
		issue(OP_REMOVE, 8'd255, 7'd0, 7'd0);
		issue(OP_INSERT, 8'd0, 7'd0, 7'd0);
		issue(OP_INSERT, 8'd0, 7'd100, 7'd0);
		issue(OP_INSERT, 8'd0, 7'd100, 7'd0);
		issue(OP_PEEK, 8'd0, 7'd0, 7'd0);
		issue(OP_INSERT, 8'd0, 7'd29, 7'd0);
		issue(OP_REMOVE, 8'd1, 7'd0, 7'd0);
		issue(OP_REMOVE, 8'd1, 7'd0, 7'd0);
		issue(OP_PEEK, 8'd0, 7'd0, 7'd0);
		issue(OP_INCREASE, 8'd3, 7'd0, 7'd0);
		issue(OP_INCREASE, 8'd3, 7'd0, 7'd100);
		issue(OP_INCREASE, 8'd2, 7'd0, 7'd7);
		issue(OP_PEEK, 8'd0, 7'd0, 7'd0);
		issue(OP_REMOVE, 8'd2, 7'd0, 7'd0);
		issue(OP_REMOVE, 8'd3, 7'd0, 7'd0);
		issue(OP_PEEK, 8'd0, 7'd0, 7'd0);
		issue(OP_INCREASE, 8'd0, 7'd0, 7'd30);
		issue(OP_PEEK, 8'd0, 7'd0, 7'd0);

		// lowered cap: inserts clamp, increases at the cap do nothing
		drain();
		set_regs(7'd0, 7'd50);
		issue(OP_INSERT, 8'd0, 7'd77, 7'd0);
		issue(OP_INSERT, 8'd0, 7'd50, 7'd0);
		issue(OP_INCREASE, 8'd4, 7'd0, 7'd1);
		issue(OP_PEEK, 8'd0, 7'd0, 7'd0);

		for (int p = 0; p < PHASES; p++) begin
			if (p == 2) idle_pct = 50;
			if (p == 4) idle_pct = 0;
			drain();
			set_regs(floors[p], caps[p]);
			repeat (PHASE_ITEMS) send_random();
		end

		drain();
		repeat (LATENCY + 16) @(posedge clk);
		$display("covered %0d commands (%0d inserts) over %0d register settings",
			sent, inserts_sent, settings_used);
		$display("results: ok %0d, none eligible %0d, full %0d, unknown id %0d",
			n_ok, n_empty, n_full, n_unknown);
		if (failures == 0 && pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
